>>> hdl/tsb_pkg.sv
// Package: shared types and constants for the tacho speed balancer.
`timescale 1ns / 1ps
`default_nettype none
package tsb_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_RSVD  = 2'd3
  } tsb_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_MAX = 2'd0,
    CFG_WIDTH_MIN = 2'd1
  } tsb_cfg_idx_t;

  localparam logic [DATA_W-1:0] WIDTH_MAX_RESET = 16'h3000;
  localparam logic [DATA_W-1:0] WIDTH_MIN_RESET = 16'h1000;
  localparam logic [DATA_W-1:0] WIDTH_NOMINAL   = 16'h2000;

  typedef struct packed {
    logic [DATA_W-1:0] last_left_capture;
    logic [DATA_W-1:0] last_right_capture;
    logic [DATA_W-1:0] left_period;
    logic [DATA_W-1:0] right_period;
    logic [DATA_W-1:0] left_width;
    logic [DATA_W-1:0] right_width;
  } tsb_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] width_max;
    logic [DATA_W-1:0] width_min;
  } tsb_cfg_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] capture_time;
  } tsb_item_t;

endpackage
`default_nettype wire

>>> hdl/tsb_if.sv
// Interfaces: input, result and configuration channels of the balancer.
`timescale 1ns / 1ps
`default_nettype none
interface tsb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] capture_time;
  modport source (output valid, output opcode, output capture_time, input ready);
  modport sink   (input valid, input opcode, input capture_time, output ready);
endinterface

interface tsb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_width;
  logic [15:0] right_width;
  logic [15:0] left_period;
  logic [15:0] right_period;
  logic        widths_changed;
  modport source (output valid, output left_width, output right_width,
                  output left_period, output right_period,
                  output widths_changed, input ready);
  modport sink   (input valid, input left_width, input right_width,
                  input left_period, input right_period,
                  input widths_changed, output ready);
endinterface

interface tsb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/tsb_core.sv
// Core: next-state logic for one transaction (period capture and width balance).
`timescale 1ns / 1ps
`default_nettype none
module tsb_core #(
  parameter int unsigned DIVISOR = 1
) (
  input  wire tsb_pkg::tsb_item_t  item,
  input  wire tsb_pkg::tsb_state_t state,
  input  wire tsb_pkg::tsb_cfg_t   cfg,
  output tsb_pkg::tsb_state_t      state_nxt,
  output logic                     changed
);
  import tsb_pkg::*;

  // Exact reciprocal divide for 16-bit dividends: q = (d * M) >> (16 + L)
  localparam int unsigned SHIFT_L = $clog2(DIVISOR);
  localparam int unsigned SHIFT   = DATA_W + SHIFT_L;
  localparam longint unsigned RECIP =
    ((64'd1 << SHIFT) + longint'(DIVISOR) - 64'd1) / longint'(DIVISOR);
  localparam int unsigned RECIP_W = DATA_W + 1;
  localparam int unsigned PROD_W  = DATA_W + RECIP_W + SHIFT_L;

  tsb_op_t             op;
  logic                right_slower;
  logic                left_slower;
  logic [DATA_W-1:0]   diff;
  logic [RECIP_W-1:0]  recip;
  logic [PROD_W-1:0]   prod;
  logic [DATA_W-1:0]   corr;
  logic [DATA_W-1:0]   grow;
  logic [DATA_W-1:0]   shrink;
  logic [DATA_W:0]     sum;
  logic [DATA_W-1:0]   grow_nxt;
  logic [DATA_W-1:0]   shrink_nxt;

  assign op           = tsb_op_t'(item.opcode);
  assign right_slower = state.right_period > state.left_period;
  assign left_slower  = state.left_period > state.right_period;
  assign diff   = right_slower ? (state.right_period - state.left_period)
                               : (state.left_period - state.right_period);
  assign recip  = RECIP[RECIP_W-1:0];
  assign prod   = PROD_W'(diff) * PROD_W'(recip);
  assign corr   = prod[SHIFT +: DATA_W];
  assign grow   = right_slower ? state.left_width : state.right_width;
  assign shrink = right_slower ? state.right_width : state.left_width;
  assign sum    = {1'b0, grow} + {1'b0, corr};

  always_comb begin
    if (sum > {1'b0, cfg.width_max}) begin
      grow_nxt   = cfg.width_max;
      shrink_nxt = cfg.width_min;
    end else begin
      grow_nxt   = sum[DATA_W-1:0];
      shrink_nxt = (shrink >= corr) ? (shrink - corr) : '0;
    end
  end

  always_comb begin
    state_nxt = state;
    changed   = 1'b0;
    case (op)
      OP_LEFT: begin
        state_nxt.left_period       = item.capture_time - state.last_left_capture;
        state_nxt.last_left_capture = item.capture_time;
      end
      OP_RIGHT: begin
        state_nxt.right_period       = item.capture_time - state.last_right_capture;
        state_nxt.last_right_capture = item.capture_time;
      end
      OP_TICK: begin
        if (right_slower) begin
          state_nxt.left_width  = grow_nxt;
          state_nxt.right_width = shrink_nxt;
          changed               = 1'b1;
        end else if (left_slower) begin
          state_nxt.right_width = grow_nxt;
          state_nxt.left_width  = shrink_nxt;
          changed               = 1'b1;
        end
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/tacho_speed_balancer_unit.sv
// Top level: tacho speed balancer with input, result and configuration channels.
//
// Usage:
//   in_if  : one transaction per event; opcode 0 is a PWM period tick,
//            1 a left tach edge, 2 a right tach edge (capture_time used on edges).
//   out_if : exactly one result per input transaction, in order, carrying both
//            pulse widths, both measured periods and widths_changed.
//   cfg_if : writes width_max (index 0) and width_min (index 1); always ready.
//            Write only while no transaction is in flight.
// Path: an accepted transaction passes the input register, then the result
//   register, before it shows at out_if. Throughput is one transaction per
//   cycle while out_if.ready is high; the divide by CORRECTION_DIVISOR is a
//   constant reciprocal multiply inside the single compute stage.
// Reset: rst_n low (synchronous) empties both registers, sets widths to 0x2000,
//   periods and captures to zero and the clamp registers to their defaults.
// Stall: while out_if.ready is low the result holds; one more transaction is
//   taken into the input register, then in_if.ready drops until the result
//   is taken.
`timescale 1ns / 1ps
`default_nettype none
module tacho_speed_balancer_unit #(
  parameter int unsigned CORRECTION_DIVISOR = 1
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tsb_in_if.sink     in_if,
  tsb_out_if.source  out_if,
  tsb_cfg_if.sink    cfg_if
);
  import tsb_pkg::*;

  tsb_item_t  item_r;
  logic       item_valid_r;
  tsb_state_t state_r;
  tsb_state_t state_nxt;
  tsb_cfg_t   cfg_r;
  logic       changed;
  logic       out_valid_r;
  logic       out_changed_r;
  logic       advance;
  logic       in_fire;

  assign advance = item_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !item_valid_r || advance;
  assign in_fire = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  tsb_core #(
    .DIVISOR (CORRECTION_DIVISOR)
  ) u_core (
    .item      (item_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .changed   (changed)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_max <= WIDTH_MAX_RESET;
      cfg_r.width_min <= WIDTH_MIN_RESET;
    end else if (cfg_if.valid) begin
      case (tsb_cfg_idx_t'(cfg_if.index))
        CFG_WIDTH_MAX: cfg_r.width_max <= cfg_if.data;
        CFG_WIDTH_MIN: cfg_r.width_min <= cfg_if.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      item_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.opcode       <= in_if.opcode;
      item_r.capture_time <= in_if.capture_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_left_capture  <= '0;
      state_r.last_right_capture <= '0;
      state_r.left_period        <= '0;
      state_r.right_period       <= '0;
      state_r.left_width         <= WIDTH_NOMINAL;
      state_r.right_width        <= WIDTH_NOMINAL;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_changed_r <= changed;
    end
  end

  // Result fields mirror the committed state; it only moves with advance.
  assign out_if.valid          = out_valid_r;
  assign out_if.left_width     = state_r.left_width;
  assign out_if.right_width    = state_r.right_width;
  assign out_if.left_period    = state_r.left_period;
  assign out_if.right_period   = state_r.right_period;
  assign out_if.widths_changed = out_changed_r;

endmodule
`default_nettype wire

>>> hdl/tsb_checker.sv
// Checker: port-level assertions for the tacho speed balancer, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module tsb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_left_period,
  input wire logic [15:0] out_right_period,
  input wire logic        out_widths_changed
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  a_change_needs_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_widths_changed |-> out_left_period != out_right_period)
    else $error("widths changed with equal periods");

endmodule

bind tacho_speed_balancer_unit tsb_checker u_tsb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_left_period    (out_if.left_period),
  .out_right_period   (out_if.right_period),
  .out_widths_changed (out_if.widths_changed)
);
`default_nettype wire

>>> bench/tb_top.sv
// Testbench for tacho_speed_balancer_unit: directed table plus random traffic against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import tsb_pkg::*;

  localparam int unsigned CORR_DIV = 1;
  localparam int LONG_HOLD = 100;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 112;

  typedef struct packed {
    logic [15:0] left_w;
    logic [15:0] right_w;
    logic [15:0] left_per;
    logic [15:0] right_per;
    logic        changed;
  } speed_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CHECKED,
    ROW_LIMITS
  } row_kind_t;

  // a: capture time, or width_max on a limits row; b: width_min
  typedef struct packed {
    row_kind_t     kind;
    tsb_op_t       op;
    logic [15:0]   a;
    logic [15:0]   b;
    speed_result_t want;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tsb_in_if  in_ch ();
  tsb_out_if out_ch ();
  tsb_cfg_if cfg_ch ();

  tacho_speed_balancer_unit #(.CORRECTION_DIVISOR(CORR_DIV)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // predictor state
  logic [15:0] lim_max, lim_min;
  logic [15:0] p_left_cap, p_right_cap, p_left_per, p_right_per, p_left_w, p_right_w;

  speed_result_t pending_widths[$];
  int errors = 0;
  int hold_requests = 0;
  int holds_done = 0;
  bit no_gaps = 1'b0;
  bit burst = 1'b0;
  int tach_time[2];
  int nominal[2];

  drow_t script [0:24] = '{
    '{ROW_CHECKED, OP_RSVD,  16'hFFFF, 16'h0000, '{16'h2000, 16'h2000, 16'h0000, 16'h0000, 1'b0}},
    '{ROW_CHECKED, OP_TICK,  16'hFFFF, 16'h0000, '{16'h2000, 16'h2000, 16'h0000, 16'h0000, 1'b0}},
    '{ROW_CHECKED, OP_LEFT,  16'h0100, 16'h0000, '{16'h2000, 16'h2000, 16'h0100, 16'h0000, 1'b0}},
    '{ROW_CHECKED, OP_RIGHT, 16'h0100, 16'h0000, '{16'h2000, 16'h2000, 16'h0100, 16'h0100, 1'b0}},
    '{ROW_CHECKED, OP_TICK,  16'h0000, 16'h0000, '{16'h2000, 16'h2000, 16'h0100, 16'h0100, 1'b0}},
    '{ROW_ITEM,    OP_RIGHT, 16'hFFFF, 16'h0000, '0},
    '{ROW_ITEM,    OP_TICK,  16'h0000, 16'h0000, '0},
    '{ROW_ITEM,    OP_LEFT,  16'h0000, 16'h0000, '0},
    '{ROW_ITEM,    OP_RIGHT, 16'h0000, 16'h0000, '0},
    '{ROW_ITEM,    OP_TICK,  16'h0000, 16'h0000, '0},
    '{ROW_ITEM,    OP_RSVD,  16'h5A5A, 16'h0000, '0},
    '{ROW_LIMITS,  OP_TICK,  16'h0800, 16'h0400, '0},
    '{ROW_ITEM,    OP_LEFT,  16'h0010, 16'h0000, '0},
    '{ROW_ITEM,    OP_TICK,  16'h0000, 16'h0000, '0},
    '{ROW_LIMITS,  OP_TICK,  16'h0000, 16'hFFFF, '0},
    '{ROW_ITEM,    OP_TICK,  16'h0000, 16'h0000, '0},
    '{ROW_LIMITS,  OP_TICK,  16'hFFFF, 16'h0000, '0},
    '{ROW_ITEM,    OP_RIGHT, 16'h0020, 16'h0000, '0},
    '{ROW_ITEM,    OP_TICK,  16'h0000, 16'h0000, '0},
    '{ROW_LIMITS,  OP_TICK,  16'h1000, 16'h0000, '0},
    '{ROW_ITEM,    OP_TICK,  16'h0000, 16'h0000, '0},
    '{ROW_LIMITS,  OP_TICK,  16'hFFFF, 16'h0000, '0},
    '{ROW_ITEM,    OP_TICK,  16'h0000, 16'h0000, '0},
    '{ROW_ITEM,    OP_TICK,  16'h0000, 16'h0000, '0},
    '{ROW_LIMITS,  OP_TICK,  WIDTH_MAX_RESET, WIDTH_MIN_RESET, '0}
  };

  // grow one side by corr; clamp and force the other to width_min, or shrink it
  function automatic void lean(inout logic [15:0] gain, inout logic [15:0] lose,
                               input logic [15:0] corr);
    logic [16:0] sum;
    sum = {1'b0, gain} + {1'b0, corr};
    if (sum > {1'b0, lim_max}) begin
      gain = lim_max;
      lose = lim_min;
    end else begin
      gain = sum[15:0];
      lose = (lose >= corr) ? lose - corr : 16'h0000;
    end
  endfunction

  function automatic speed_result_t balance_step(tsb_op_t op, logic [15:0] cap);
    speed_result_t r;
    logic [15:0] corr;
    r.changed = 1'b0;
    case (op)
      OP_LEFT: begin
        p_left_per = cap - p_left_cap;
        p_left_cap = cap;
      end
      OP_RIGHT: begin
        p_right_per = cap - p_right_cap;
        p_right_cap = cap;
      end
      OP_TICK: begin
        if (p_right_per > p_left_per) begin
          corr = 16'((p_right_per - p_left_per) / CORR_DIV);
          lean(p_left_w, p_right_w, corr);
          r.changed = 1'b1;
        end else if (p_left_per > p_right_per) begin
          corr = 16'((p_left_per - p_right_per) / CORR_DIV);
          lean(p_right_w, p_left_w, corr);
          r.changed = 1'b1;
        end
      end
      default: ;
    endcase
    r.left_w = p_left_w;
    r.right_w = p_right_w;
    r.left_per = p_left_per;
    r.right_per = p_right_per;
    return r;
  endfunction

  function automatic int tx_gap();
    int r;
    if (no_gaps || burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rx_stall();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] next_capture(int side);
    if ($urandom_range(0, 99) < 15)
      tach_time[side] = $urandom_range(0, 16'hFFFF);
    else
      tach_time[side] = tach_time[side] + nominal[side] + $urandom_range(0, 64);
    return tach_time[side][15:0];
  endfunction

  task automatic send_item(input tsb_op_t op, input logic [15:0] cap, input bit typed,
                           input speed_result_t want);
    int gap;
    speed_result_t exp_r;
    gap = tx_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.capture_time <= cap;
    do @(posedge clk); while (!in_ch.ready);
    exp_r = balance_step(op, cap);
    pending_widths.push_back(typed ? want : exp_r);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_widths.size() != 0);
  endtask

  task automatic set_limits(input logic [15:0] wmax, input logic [15:0] wmin);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_WIDTH_MAX;
    cfg_ch.data <= wmax;
    do @(posedge clk); while (!cfg_ch.ready);
    lim_max = wmax;
    cfg_ch.index <= CFG_WIDTH_MIN;
    cfg_ch.data <= wmin;
    do @(posedge clk); while (!cfg_ch.ready);
    lim_min = wmin;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : result_ready
    int n;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        n = LONG_HOLD;
      end else begin
        n = rx_stall();
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    speed_result_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.left_width, out_ch.right_width, out_ch.left_period,
              out_ch.right_period, out_ch.widths_changed};
      if (pending_widths.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: lw=%h rw=%h lp=%h rp=%h chg=%b",
                   got.left_w, got.right_w, got.left_per, got.right_per, got.changed);
      end else begin
        exp_r = pending_widths.pop_front();
        if (got.left_w !== exp_r.left_w || got.right_w !== exp_r.right_w ||
            got.left_per !== exp_r.left_per || got.right_per !== exp_r.right_per ||
            got.changed !== exp_r.changed) begin
          errors++;
          if (errors <= 10)
            $display(
              "mismatch: exp lw=%h rw=%h lp=%h rp=%h chg=%b / got lw=%h rw=%h lp=%h rp=%h chg=%b",
              exp_r.left_w, exp_r.right_w, exp_r.left_per, exp_r.right_per,
              exp_r.changed, got.left_w, got.right_w, got.left_per,
              got.right_per, got.changed);
        end
      end
    end
  end

  initial begin : stimulus
    drow_t row;
    int r;
    logic [15:0] mx, mn;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_TICK;
    in_ch.capture_time = 16'h0000;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_WIDTH_MAX;
    cfg_ch.data = 16'h0000;
    lim_max = WIDTH_MAX_RESET;
    lim_min = WIDTH_MIN_RESET;
    p_left_cap = '0;
    p_right_cap = '0;
    p_left_per = '0;
    p_right_per = '0;
    p_left_w = WIDTH_NOMINAL;
    p_right_w = WIDTH_NOMINAL;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      row = script[i];
      if (row.kind == ROW_LIMITS)
        set_limits(row.a, row.b);
      else
        send_item(row.op, row.a, row.kind == ROW_CHECKED, row.want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: begin
            mx = 16'hFFFF;
            mn = 16'h0000;
          end
          2: begin
            mx = 16'h0000;
            mn = 16'hFFFF;
          end
          default: begin
            mx = 16'($urandom);
            mn = 16'($urandom);
            if ($urandom_range(0, 1)) begin
              mx = 16'($urandom_range(16'h1800, 16'hC000));
              mn = 16'($urandom_range(0, mx));
            end
          end
        endcase
        set_limits(mx, mn);
      end
      no_gaps = (phase % 4 == 3);
      nominal[0] = $urandom_range(16'h0200, 16'h3000);
      nominal[1] = nominal[0] + $urandom_range(0, 16'h0200) - 16'h0100;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long result stall with back-to-back input to back the pipe up
        if (phase == 4 && k == 30) begin
          hold_requests++;
          burst = 1'b1;
        end
        if (phase == 4 && k == 70) burst = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 40)
          send_item(OP_TICK, 16'($urandom), 1'b0, '0);
        else if (r < 68)
          send_item(OP_LEFT, next_capture(0), 1'b0, '0);
        else if (r < 96)
          send_item(OP_RIGHT, next_capture(1), 1'b0, '0);
        else
          send_item(OP_RSVD, 16'($urandom), 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("** tacho_speed_balancer_unit: PASSED **");
    else
      $display("** tacho_speed_balancer_unit: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("** tacho_speed_balancer_unit: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
hdl/tsb_pkg.sv
hdl/tsb_if.sv
hdl/tsb_core.sv
hdl/tacho_speed_balancer_unit.sv
hdl/tsb_checker.sv
bench/tb_top.sv
